// File: hdl/l2sq_pkg.sv
`default_nettype none

package l2sq_pkg;

    // Port widths fixed by the interface
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int LOG_W = 32;

    // Width of one multiplier operand chunk
    localparam int CHUNK_W = 32;

    // Coarse normalization step, in bit positions
    localparam int NORM_STEP = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_NEG_LOG = 2'd0;
    localparam logic [OP_W-1:0] OP_LOG     = 2'd1;
    localparam logic [OP_W-1:0] OP_LOG1P   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_ROUND,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// File: hdl/log2_by_repeated_squaring_core.sv
`default_nettype none
// Steps: input transfer, normalization of the argument, FRAC_BITS squaring rounds that each
// square the argument one chunk pair at a time, a final check, then the output register.
// The one shared 32x32 multiplier serves every chunk pair; a zero argument or an exact
// power of two finishes early.
// Throughput: one item at a time; the next transfer is taken once the core is idle.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the output valid.

module log2_by_repeated_squaring_core #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [l2sq_pkg::OP_W-1:0]    operation,
    input  wire logic [l2sq_pkg::VAL_W-1:0]   value_in,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [l2sq_pkg::LOG_W-1:0]        log_out
);

    import l2sq_pkg::*;

    // Chunks per operand, accumulator width and counter widths
    localparam int NCH  = (FRAC_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int YW   = NCH * CHUNK_W;
    localparam int AW   = 2 * YW;
    localparam int RW   = $clog2(FRAC_BITS + 1);
    localparam int PIW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [RW-1:0]  ROUNDS = RW'(FRAC_BITS);
    localparam logic [PIW-1:0] PI_LAST = PIW'(NCH - 1);

    state_t                 state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [FRAC_BITS-1:0]   y_reg, y_next;
    logic [FRAC_BITS-1:0]   x_reg, x_next;
    logic [RW-1:0]          round_reg, round_next;
    logic [PIW-1:0]         pi_reg, pi_next;
    logic [PIW-1:0]         pj_reg, pj_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LOG_W-1:0]       log_out_reg, log_out_next;

    // Datapath intermediates
    logic [FRAC_BITS+VAL_W-1:0]   val_ext;
    logic [FRAC_BITS-1:0]         y_init;
    logic [YW-1:0]                y_pad;
    logic [CHUNK_W-1:0]           mul_a, mul_b;
    logic [2*CHUNK_W-1:0]         pp;
    logic [AW-1:0]                sum;
    logic [2*FRAC_BITS-1:0]       prod;
    logic                         z;
    logic [FRAC_BITS-1:0]         x_res;
    logic [FRAC_BITS+LOG_W-1:0]   res_ext;
    logic                         pp_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign log_out   = log_out_reg;

    // Argument conditioning: keep low FRAC_BITS bits, fold in one-plus form
    always_comb
    begin
        val_ext = {{FRAC_BITS{1'b0}}, value_in};
        y_init  = val_ext[FRAC_BITS-1:0];
        if (operation == OP_LOG1P)
        begin
            y_init = (y_init >> 1) | HALF;
        end
    end

    // Shared multiplier: one chunk pair per cycle, accumulated into the square
    always_comb
    begin
        y_pad   = YW'(y_reg);
        mul_a   = y_pad[int'(pi_reg)*CHUNK_W +: CHUNK_W];
        mul_b   = y_pad[int'(pj_reg)*CHUNK_W +: CHUNK_W];
        pp      = {{CHUNK_W{1'b0}}, mul_a} * {{CHUNK_W{1'b0}}, mul_b};
        if (NCH == 1)
        begin
            sum = AW'(pp);
        end
        else
        begin
            sum = acc_reg + (AW'(pp) << (CHUNK_W * (int'(pi_reg) + int'(pj_reg))));
        end
        prod    = sum[2*FRAC_BITS-1:0];
        z       = ~prod[2*FRAC_BITS-1];
        pp_last = (pi_reg == PI_LAST) && (pj_reg == PI_LAST);
    end

    // Result: negate for log2 and log2(1+y), then fit to the output width
    always_comb
    begin
        x_res = x_reg;
        if (op_reg == OP_LOG || op_reg == OP_LOG1P)
        begin
            x_res = -x_reg;
        end
        res_ext = {{LOG_W{1'b0}}, x_res};
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        round_next     = round_reg;
        pi_next        = pi_reg;
        pj_next        = pj_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        log_out_next   = log_out_reg;

        // Drop the output once the downstream side takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    y_next     = y_init;
                    x_next     = '0;
                    round_next = '0;
                    pi_next    = '0;
                    pj_next    = '0;
                    acc_next   = '0;
                    // A zero argument answers zero right away
                    state_next = (y_init == '0) ? ST_FIN : ST_NORM;
                end
            end
            ST_NORM:
            begin
                // Shift the argument up to [1/2, 1), counting the shift into x
                if (y_reg[FRAC_BITS-1])
                begin
                    state_next = ST_ROUND;
                end
                else if (y_reg[FRAC_BITS-1 -: NORM_STEP] == '0)
                begin
                    y_next = y_reg << NORM_STEP;
                    x_next = x_reg + FRAC_BITS'(NORM_STEP);
                end
                else
                begin
                    y_next = y_reg << 1;
                    x_next = x_reg + FRAC_BITS'(1);
                end
            end
            ST_ROUND:
            begin
                if (round_reg == ROUNDS)
                begin
                    state_next = ST_FIN;
                end
                else if (y_reg == HALF)
                begin
                    // Exact one half: the remaining rounds reduce to an add and a shift of x
                    x_next     = (x_reg + FRAC_BITS'(1)) << (ROUNDS - round_reg);
                    state_next = ST_FIN;
                end
                else if (pp_last)
                begin
                    // Square complete: normalize by at most one bit
                    y_next     = z ? prod[2*FRAC_BITS-2 -: FRAC_BITS]
                                   : prod[2*FRAC_BITS-1 -: FRAC_BITS];
                    x_next     = (x_reg << 1) + FRAC_BITS'(z);
                    round_next = round_reg + RW'(1);
                    pi_next    = '0;
                    pj_next    = '0;
                    acc_next   = '0;
                end
                else
                begin
                    // Advance to the next chunk pair
                    acc_next = sum;
                    if (pj_reg == PI_LAST)
                    begin
                        pj_next = '0;
                        pi_next = pi_reg + PIW'(1);
                    end
                    else
                    begin
                        pj_next = pj_reg + PIW'(1);
                    end
                end
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    log_out_next   = res_ext[LOG_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        y_reg       <= y_next;
        x_reg       <= x_next;
        round_reg   <= round_next;
        pi_reg      <= pi_next;
        pj_reg      <= pj_next;
        acc_reg     <= acc_next;
        log_out_reg <= log_out_next;
    end

    // A transfer always leaves the core busy on the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("core ready right after an input transfer");

    // Squaring rounds only ever see a normalized argument
    a_round_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> y_reg[FRAC_BITS-1])
        else $error("squaring round on an unnormalized argument");

    // A new result appears only from the finishing step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the finishing step");

    // The round counter never runs past the round count
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= ROUNDS))
        else $error("round counter out of range");

endmodule

`default_nettype wire
